/* rtl/core/chm_pkg.sv */
// chm_pkg: shared types and codes for the chained hash id map.
// No dependencies.
package chm_pkg;

  localparam int unsigned CfgBits = 7;
  localparam int unsigned StatBits = 2;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic {
    FN_LOOKUP = 1'b0,
    FN_SET    = 1'b1
  } func_e;

endpackage

/* rtl/core/chm_ram.sv */
// chm_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
module chm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/core/chm_front.sv */
// chm_front: accepts commands and computes the bucket (key mod clamped count) serially.
// Depends on chm_pkg.
module chm_front #(
  parameter int unsigned KeyBits = 32,
  parameter int unsigned ValueBits = 32,
  parameter int unsigned MaxBuckets = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          func_i,
  input  logic [KeyBits-1:0]            key_i,
  input  logic [ValueBits-1:0]          value_i,
  input  logic [chm_pkg::CfgBits-1:0]   bucket_count_i,
  input  logic                          queue_full_i,
  output logic                          busy_o,
  output logic                          push_o,
  output logic                          func_o,
  output logic [KeyBits-1:0]            key_o,
  output logic [ValueBits-1:0]          value_o,
  output logic [$clog2(MaxBuckets+1)-1:0] bucket_o
);
  localparam int unsigned BW = $clog2(MaxBuckets+1);
  localparam int unsigned CntW = $clog2(KeyBits+1);

  // restoring remainder, one key bit per cycle
  logic              act_q, act_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [KeyBits-1:0] sh_q, sh_d;
  logic [BW:0]       rem_q, rem_d;
  logic [BW:0]       div_q, div_d;
  logic              func_q, func_d;
  logic [KeyBits-1:0] key_q, key_d;
  logic [ValueBits-1:0] val_q, val_d;
  logic [BW:0]       trial;
  logic [BW:0]       n;

  always_comb begin
    n = (BW+1)'(bucket_count_i);
    if (n == '0) n = (BW+1)'(1);
    if (n > (BW+1)'(MaxBuckets)) n = (BW+1)'(MaxBuckets);
  end

  assign busy_o = act_q | done_q;
  assign trial = {rem_q[BW-1:0], sh_q[KeyBits-1]};

  always_comb begin
    act_d = act_q; done_d = done_q; cnt_d = cnt_q; sh_d = sh_q;
    rem_d = rem_q; div_d = div_q; func_d = func_q; key_d = key_q; val_d = val_q;
    push_o = 1'b0;
    if (done_q) begin
      if (!queue_full_i) begin
        push_o = 1'b1;
        done_d = 1'b0;
      end
    end else if (act_q) begin
      rem_d = (trial >= div_q) ? trial - div_q : trial;
      sh_d = sh_q << 1;
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        act_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      act_d = 1'b1; cnt_d = CntW'(KeyBits); sh_d = key_i; rem_d = '0; div_d = n;
      func_d = func_i; key_d = key_i; val_d = value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      act_q <= act_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d; rem_q <= rem_d; div_q <= div_d;
    func_q <= func_d; key_q <= key_d; val_q <= val_d;
  end

  assign func_o = func_q;
  assign key_o = key_q;
  assign value_o = val_q;
  assign bucket_o = rem_q[BW-1:0];
endmodule

/* rtl/core/chm_queue.sv */
// chm_queue: two-entry command queue between front and back.
// No dependencies.
module chm_queue #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic             full_o,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] ent_q [2];
  logic rp_q, wp_q;
  logic [1:0] cnt_q;
  assign full_o = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = ent_q[rp_q];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q <= 1'b0; wp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= wdata_i;
  end
endmodule

/* rtl/core/chm_back.sv */
// chm_back: walks the chain in node RAMs, updates or inserts, emits results.
// Depends on chm_pkg and chm_ram.
module chm_back #(
  parameter int unsigned KeyBits = 32,
  parameter int unsigned ValueBits = 32,
  parameter int unsigned MaxBuckets = 64,
  parameter int unsigned PoolNodes = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      empty_i,
  input  logic                      func_i,
  input  logic [KeyBits-1:0]        key_i,
  input  logic [ValueBits-1:0]      value_i,
  input  logic [$clog2(MaxBuckets+1)-1:0] bucket_i,
  output logic                      pop_o,
  output logic                      done_o,
  output logic                      found_o,
  output logic [ValueBits-1:0]      value_out_o,
  output logic [chm_pkg::StatBits-1:0] status_o
);
  localparam int unsigned NW = $clog2(PoolNodes);
  localparam int unsigned PW = $clog2(PoolNodes+1);
  localparam int unsigned HW = $clog2(MaxBuckets);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_HEAD = 5'b00010,
    S_READ = 5'b00100,
    S_CMP  = 5'b01000,
    S_FIN  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [MaxBuckets-1:0] hvld_q;   // bucket head written since reset
  logic [PW-1:0] hd_q, hd_d;       // chain head at walk start
  logic [PW-1:0] cur_q, cur_d;
  logic [PW-1:0] used_q;
  logic [PW-1:0] steps_q, steps_d;
  logic          hit_q, hit_d;
  logic          done_q;
  logic          found_q;
  logic [ValueBits-1:0] vout_q;
  logic [chm_pkg::StatBits-1:0] stat_q;
  logic [KeyBits-1:0] rkey;
  logic [ValueBits-1:0] rval;
  logic [PW-1:0] rlink;
  logic [PW-1:0] rhead;
  logic [PW-1:0] head;
  logic [HW-1:0] bkt;
  logic kwe, vwe;
  logic [NW-1:0] vaddr;

  assign bkt = bucket_i[HW-1:0];
  // unwritten buckets read as the null marker
  assign head = hvld_q[bkt] ? rhead : PW'(PoolNodes);

  chm_ram #(.Width(PW), .Depth(MaxBuckets)) u_heads (
    .clk_i, .we_i(kwe), .waddr_i(bkt), .wdata_i(used_q),
    .raddr_i(bkt), .rdata_o(rhead));
  chm_ram #(.Width(KeyBits), .Depth(PoolNodes)) u_keys (
    .clk_i, .we_i(kwe), .waddr_i(used_q[NW-1:0]), .wdata_i(key_i),
    .raddr_i(cur_q[NW-1:0]), .rdata_o(rkey));
  chm_ram #(.Width(ValueBits), .Depth(PoolNodes)) u_vals (
    .clk_i, .we_i(vwe), .waddr_i(vaddr), .wdata_i(value_i),
    .raddr_i(cur_q[NW-1:0]), .rdata_o(rval));
  chm_ram #(.Width(PW), .Depth(PoolNodes)) u_links (
    .clk_i, .we_i(kwe), .waddr_i(used_q[NW-1:0]), .wdata_i(hd_q),
    .raddr_i(cur_q[NW-1:0]), .rdata_o(rlink));

  always_comb begin
    state_d = state_q; cur_d = cur_q; steps_d = steps_q; hit_d = hit_q; hd_d = hd_q;
    pop_o = 1'b0; kwe = 1'b0; vwe = 1'b0; vaddr = cur_q[NW-1:0];
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          steps_d = '0; hit_d = 1'b0; state_d = S_HEAD;
        end
      end
      S_HEAD: begin
        cur_d = head; hd_d = head;
        state_d = (head >= PW'(PoolNodes)) ? S_FIN : S_READ;
      end
      S_READ: state_d = S_CMP;
      S_CMP: begin
        if (rkey == key_i) begin
          hit_d = 1'b1; state_d = S_FIN;
        end else if (rlink >= PW'(PoolNodes) || steps_q == PW'(PoolNodes - 1)) begin
          state_d = S_FIN;
        end else begin
          cur_d = rlink; steps_d = steps_q + PW'(1); state_d = S_READ;
        end
      end
      S_FIN: begin
        pop_o = 1'b1; state_d = S_IDLE;
        if (func_i == chm_pkg::FN_SET) begin
          if (hit_q) vwe = 1'b1;
          else if (used_q < PW'(PoolNodes)) begin
            kwe = 1'b1; vwe = 1'b1; vaddr = used_q[NW-1:0];
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; used_q <= '0; done_q <= 1'b0; hvld_q <= '0;
    end else begin
      state_q <= state_d;
      done_q <= pop_o;
      if (kwe) begin
        hvld_q[bkt] <= 1'b1;
        used_q <= used_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d; steps_q <= steps_d; hit_q <= hit_d; hd_q <= hd_d;
    if (pop_o) begin
      found_q <= hit_q;
      vout_q <= (func_i == chm_pkg::FN_LOOKUP && hit_q) ? rval : '0;
      if (func_i == chm_pkg::FN_LOOKUP)
        stat_q <= hit_q ? chm_pkg::ST_DONE : chm_pkg::ST_MISS;
      else
        stat_q <= (!hit_q && used_q >= PW'(PoolNodes)) ? chm_pkg::ST_FULL
                                                       : chm_pkg::ST_DONE;
    end
  end

  assign done_o = done_q;
  assign found_o = found_q;
  assign value_out_o = vout_q;
  assign status_o = stat_q;
endmodule

/* rtl/core/chained_hash_id_map_top.sv */
// chained_hash_id_map_top: top level of the chained hash id map.
// Depends on chm_pkg, chm_front, chm_queue, chm_back, chm_ram.
//
// Channel   Dir  Handshake               Word
// cmd       in   start && !busy          func_i, key_i, value_i
// result    out  done_o (one cycle)      found_o, value_out_o, status_o
// cfg       in   cfg_valid_i && cfg_ready_o  cfg_data_i (bucket_count)
//
// Steps: front computes one remainder bit per cycle, then holds the word in
// a handoff state until the queue has room; back reads the chain head, then
// walks the chain through the registered node RAM read (read, then compare
// per node), then finishes, popping the queue and raising the registered
// strobe. Front and back overlap via a two-entry queue. Reset empties the
// chain heads at once (one valid bit per bucket); node RAMs are never cleared.
// The receiver cannot stall; the front stalls only when the queue is full.
module chained_hash_id_map_top #(
  parameter int unsigned MAX_BUCKETS = 64,
  parameter int unsigned POOL_NODES = 256,
  parameter int unsigned KEY_BITS = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         func_i,
  input  logic [KEY_BITS-1:0]          key_i,
  input  logic [VALUE_BITS-1:0]        value_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [chm_pkg::CfgBits-1:0]  cfg_data_i,
  output logic                         done_o,
  output logic                         found_o,
  output logic [VALUE_BITS-1:0]        value_out_o,
  output logic [chm_pkg::StatBits-1:0] status_o
);
  localparam int unsigned BW = $clog2(MAX_BUCKETS+1);
  localparam int unsigned QW = 1 + KEY_BITS + VALUE_BITS + BW;

  logic [chm_pkg::CfgBits-1:0] bcount_q;
  logic f_push, f_func, q_full, q_empty, pop;
  logic [KEY_BITS-1:0] f_key;
  logic [VALUE_BITS-1:0] f_val;
  logic [BW-1:0] f_bkt;
  logic [QW-1:0] q_out;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bcount_q <= chm_pkg::CfgBits'(MAX_BUCKETS);
    else if (cfg_valid_i) bcount_q <= cfg_data_i;
  end

  chm_front #(.KeyBits(KEY_BITS), .ValueBits(VALUE_BITS), .MaxBuckets(MAX_BUCKETS))
  u_front (
    .clk_i, .rst_ni, .start_i(start), .func_i, .key_i, .value_i,
    .bucket_count_i(bcount_q), .queue_full_i(q_full), .busy_o(busy),
    .push_o(f_push), .func_o(f_func), .key_o(f_key), .value_o(f_val),
    .bucket_o(f_bkt));

  chm_queue #(.Width(QW)) u_queue (
    .clk_i, .rst_ni, .push_i(f_push), .wdata_i({f_func, f_key, f_val, f_bkt}),
    .pop_i(pop), .full_o(q_full), .empty_o(q_empty), .rdata_o(q_out));

  chm_back #(.KeyBits(KEY_BITS), .ValueBits(VALUE_BITS),
             .MaxBuckets(MAX_BUCKETS), .PoolNodes(POOL_NODES)) u_back (
    .clk_i, .rst_ni, .empty_i(q_empty),
    .func_i(q_out[QW-1]),
    .key_i(q_out[QW-2 -: KEY_BITS]),
    .value_i(q_out[BW+VALUE_BITS-1 -: VALUE_BITS]),
    .bucket_i(q_out[BW-1:0]),
    .pop_o(pop), .done_o, .found_o, .value_out_o, .status_o);
endmodule

/* rtl/core/chm_checker.sv */
// chm_checker: port-level assertions for chained_hash_id_map_top, with bind.
// Depends on chm_pkg.
module chm_checker #(
  parameter int unsigned VALUE_BITS = 32
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start,
  input logic                         busy,
  input logic                         done_o,
  input logic                         found_o,
  input logic [VALUE_BITS-1:0]        value_out_o,
  input logic [chm_pkg::StatBits-1:0] status_o
);
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o != 2'd3) else $error("bad status");
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != chm_pkg::ST_DONE |-> !found_o && value_out_o == '0)
    else $error("failure with data");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised");
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("strobe too long");
endmodule

bind chained_hash_id_map_top chm_checker #(.VALUE_BITS(VALUE_BITS)) u_chk (
  .clk_i, .rst_ni, .start, .busy, .done_o, .found_o, .value_out_o, .status_o);
